// File: hdl/lcc_pkg.sv
// shared types, constants and the class decode for the luhn card classifier
package lcc_pkg;

  // widths of the beat fields
  localparam int DIGIT_W = 4;
  localparam int COUNT_W = 5;
  localparam int SUM_W   = 4;

  // length, digit and modulus values for the class decode, the count saturation and the mod ten fold
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 5'd31;
  localparam logic [COUNT_W-1:0] LEN_SHORT  = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_MID    = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_LONG   = 5'd16;
  localparam logic [DIGIT_W-1:0] DIG_ONE    = 4'd1;
  localparam logic [DIGIT_W-1:0] DIG_THREE  = 4'd3;
  localparam logic [DIGIT_W-1:0] DIG_FOUR   = 4'd4;
  localparam logic [DIGIT_W-1:0] DIG_FIVE   = 4'd5;
  localparam logic [DIGIT_W-1:0] DIG_SEVEN  = 4'd7;
  localparam logic [DIGIT_W-1:0] DIG_NINE   = 4'd9;
  localparam logic [DIGIT_W:0]   MOD_TEN    = 5'd10;
  localparam logic [DIGIT_W:0]   MOD_TWENTY = 5'd20;
  localparam logic [DIGIT_W:0]   MOD_THIRTY = 5'd30;

  typedef enum logic [1:0] {
    CLS_NONE    = 2'd0,
    CLS_LEAD4   = 2'd1,
    CLS_LEAD3X  = 2'd2,
    CLS_LEAD5X  = 2'd3
  } class_t;

  // one result record, class code in the lowest bits
  typedef struct packed {
    logic [COUNT_W-1:0] length;
    logic               checksum_ok;
    class_t             class_code;
  } result_t;

  // queue status seen by the input handshake at the top and by the back end
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic class_t classify(input logic [COUNT_W-1:0] len,
                                      input logic [DIGIT_W-1:0] lead,
                                      input logic [DIGIT_W-1:0] second);
    class_t c;
    c = CLS_NONE;
    if ((len == LEN_SHORT || len == LEN_LONG) && lead == DIG_FOUR) begin
      c = CLS_LEAD4;
    end else if (len == LEN_MID && lead == DIG_THREE &&
                 (second == DIG_FOUR || second == DIG_SEVEN)) begin
      c = CLS_LEAD3X;
    end else if (len == LEN_LONG && lead == DIG_FIVE &&
                 second >= DIG_ONE && second <= DIG_FIVE) begin
      c = CLS_LEAD5X;
    end
    return c;
  endfunction

endpackage

// File: hdl/lcc_front.sv
// front end: luhn accumulation per digit and result record on the last digit
module lcc_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [lcc_pkg::DIGIT_W-1:0] digit,
  input  logic                        last,
  output logic                        push,
  output lcc_pkg::result_t            push_data
);

  logic [lcc_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [lcc_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic [lcc_pkg::DIGIT_W-1:0] prev_r, prev_nxt;

  logic [lcc_pkg::DIGIT_W:0]   dbl;
  logic [lcc_pkg::DIGIT_W:0]   term;
  logic [lcc_pkg::DIGIT_W:0]   raw_sum;
  logic [lcc_pkg::SUM_W-1:0]   new_sum;
  logic [lcc_pkg::COUNT_W-1:0] new_count;

  always_comb begin
    dbl = {digit, 1'b0};
    if (count_r[0]) begin
      term = (dbl > {1'b0, lcc_pkg::DIG_NINE}) ? dbl - {1'b0, lcc_pkg::DIG_NINE} : dbl;
    end else begin
      term = {1'b0, digit};
    end
    raw_sum = {1'b0, sum_r} + term;
    // raw sum reaches thirty at most, three compares cover the mod ten
    if (raw_sum >= lcc_pkg::MOD_THIRTY) begin
      new_sum = lcc_pkg::SUM_W'(raw_sum - lcc_pkg::MOD_THIRTY);
    end else if (raw_sum >= lcc_pkg::MOD_TWENTY) begin
      new_sum = lcc_pkg::SUM_W'(raw_sum - lcc_pkg::MOD_TWENTY);
    end else if (raw_sum >= lcc_pkg::MOD_TEN) begin
      new_sum = lcc_pkg::SUM_W'(raw_sum - lcc_pkg::MOD_TEN);
    end else begin
      new_sum = lcc_pkg::SUM_W'(raw_sum);
    end
    new_count = (count_r == lcc_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
  end

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    prev_nxt  = prev_r;
    if (accept) begin
      if (last) begin
        count_nxt = '0;
        sum_nxt   = '0;
        prev_nxt  = '0;
      end else begin
        count_nxt = new_count;
        sum_nxt   = new_sum;
        prev_nxt  = digit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      prev_r  <= '0;
    end else begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      prev_r  <= prev_nxt;
    end
  end

  assign push                  = accept && last;
  assign push_data.class_code  = lcc_pkg::classify(new_count, digit, prev_r);
  assign push_data.checksum_ok = (new_sum == '0);
  assign push_data.length      = new_count;

endmodule

// File: hdl/lcc_fifo.sv
// short result queue between the front end and the output stage
module lcc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcc_pkg::result_t push_data,
  input  logic             pop,
  output lcc_pkg::result_t pop_data,
  output lcc_pkg::q_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  lcc_pkg::result_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/lcc_back.sv
// back end: output register that drains the queue onto the result channel
module lcc_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lcc_pkg::q_stat_t stat,
  input  lcc_pkg::result_t q_data,
  output logic             pop,
  input  logic             out_tready,
  output logic             out_tvalid,
  output lcc_pkg::result_t out_data
);

  logic             valid_r, valid_nxt;
  lcc_pkg::result_t data_r;

  // refill whenever the register is free or its beat leaves this cycle
  assign pop = !stat.empty && (!valid_r || out_tready);

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= q_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_data   = data_r;

endmodule

// File: hdl/card_number_luhn_classifier_top.sv
// top level of the luhn card number checker and classifier
//
// digits of a card number enter on the in_ stream, least significant first,
// one per beat; in_tlast marks the most significant digit and closes the
// number. a closed number yields one result beat on the out_ stream with the
// class code, the luhn pass flag and the digit count (saturating at 31).
// beats without in_tlast yield nothing.
// throughput: one digit per cycle while the queue is not full; the luhn add, the mod ten fold and the
// class decode all settle in the front end within the accepting cycle.
// a result beat passes the queue and then the output register: the queue takes the
// record on the edge that took its last digit, and the output register loads it once
// that register is free or its beat leaves; out_tvalid then shows it.
// a queue of QUEUE_DEPTH records sits between front end and output register;
// when the receiver stalls, results pile up there and in_tready drops only
// once the queue is full, so up to QUEUE_DEPTH + 1 results can be held.
// reset (rst_n low, synchronous) clears the running sum, the digit count,
// the saved digit, the queue and the output valid; no clearing pass follows.
module card_number_luhn_classifier_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] digit, [7:4] zero fill
  input  logic       in_tlast,   // last: most significant digit
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] class_code, [2] checksum_ok, [7:3] length
);

  logic             in_accept;
  logic             push;
  logic             pop;
  lcc_pkg::result_t push_data;
  lcc_pkg::result_t q_data;
  lcc_pkg::result_t out_data;
  lcc_pkg::q_stat_t stat;

  // hold the input only while the queue cannot take a record
  assign in_tready = !stat.full;
  assign in_accept = in_tvalid && in_tready;

  lcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .digit     (in_tdata[lcc_pkg::DIGIT_W-1:0]),
    .last      (in_tlast),
    .push      (push),
    .push_data (push_data)
  );

  lcc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (q_data),
    .stat      (stat)
  );

  lcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .q_data     (q_data),
    .pop        (pop),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_data)
  );

  assign out_tdata = out_data;

  // a record is never offered to a full queue
  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("result record pushed into full queue");

  // every accepted closing digit produces a record
  a_last_pushes : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |-> push)
    else $error("closing digit accepted without a record");

  // nothing is popped from an empty queue
  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  // the result stream is quiet right after reset
  a_reset_quiet : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat offered right after reset");

endmodule
